FILE: src/hri_pkg.sv
package hri_pkg;

   // Field widths fixed by the interface
   localparam int BASE_W  = 9;
   localparam int Q32_W   = 32;
   localparam int Q16_W   = 16;
   localparam int Q8_W    = 8;

   // Base register
   localparam logic [BASE_W-1:0] BASE_RESET = 9'd2;
   localparam logic [BASE_W-1:0] BASE_MIN   = 9'd2;

   // Restoring steps of the digit divider done in one cycle
   localparam int DIV_STEPS = 4;

   // Parameter defaults
   localparam int INDEX_WIDTH_DEF   = 32;
   localparam int FRACTION_BITS_DEF = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ACCUM,
      ST_FRACT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic accum;
      logic frac_step;
   } hri_cmd_type;

   typedef struct packed {
      logic quot_zero;
   } hri_status_type;

endpackage

FILE: src/halton_radical_inverse.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   req_sample_index
// rsp_      out        rsp_valid / rsp_stall   rsp_fraction_q32/_q16/_q8, rsp_upper_half
// csr_      in         csr_write_enable        csr_write_data (base)
//
// An item is loaded, then for each base digit of the index (at least one) the divider
// runs its restoring steps and the digit is accumulated; Q = max(FRACTION_BITS,16)
// fraction steps follow, then the result waits in the output step for a free slot.
// Reset is synchronous, active high, and clears the controller, the result valid
// and the base register (to two). A stalled result holds in the output register;
// the next item is taken meanwhile and waits in its last step until the slot frees.
module halton_radical_inverse
   import hri_pkg::*;
#(
   parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [INDEX_WIDTH-1:0] req_sample_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [Q32_W-1:0]       rsp_fraction_q32,
   output logic [Q16_W-1:0]       rsp_fraction_q16,
   output logic [Q8_W-1:0]        rsp_fraction_q8,
   output logic                   rsp_upper_half,
   input  logic                   csr_write_enable,
   input  logic [BASE_W-1:0]      csr_write_data
);

   localparam int QBITS = (FRACTION_BITS > Q16_W) ? FRACTION_BITS : Q16_W;

   hri_cmd_type    cmd;
   hri_status_type status;
   logic           busy;
   logic           out_load;
   logic           out_free;
   logic [QBITS-1:0] quotient;

   logic [BASE_W-1:0] base_ff, base_in;
   logic [BASE_W-1:0] base_eff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [Q32_W-1:0]  q32_ff, q32_in;
   logic [Q16_W-1:0]  q16_ff, q16_in;
   logic [Q8_W-1:0]   q8_ff, q8_in;
   logic              half_ff, half_in;
   logic [63:0]       frac_ext;

   // Base register; radices below two act as two
   assign base_in  = csr_write_enable ? csr_write_data : base_ff;
   assign base_eff = (base_ff < BASE_MIN) ? BASE_MIN : base_ff;

   hri_ctrl #(
      .INDEX_WIDTH   (INDEX_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .out_load  (out_load)
   );

   hri_datapath #(
      .INDEX_WIDTH   (INDEX_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .sample_index (req_sample_index),
      .base         (base_eff),
      .status       (status),
      .quotient     (quotient)
   );

   // Take a new item only while the controller is idle
   assign req_stall = busy;

   // The output slot is free when empty or when its transfer completes now
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Slice the quotient: the top FRACTION_BITS bits, then the 16/8/1-bit views
   assign frac_ext = 64'(quotient[QBITS-1 -: FRACTION_BITS]);
   assign q32_in   = out_load ? frac_ext[Q32_W-1:0] : q32_ff;
   assign q16_in   = out_load ? quotient[QBITS-1 -: Q16_W] : q16_ff;
   assign q8_in    = out_load ? quotient[QBITS-1 -: Q8_W] : q8_ff;
   assign half_in  = out_load ? quotient[QBITS-1] : half_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q32_ff  <= q32_in;
      q16_ff  <= q16_in;
      q8_ff   <= q8_in;
      half_ff <= half_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fraction_q32 = q32_ff;
   assign rsp_fraction_q16 = q16_ff;
   assign rsp_fraction_q8  = q8_ff;
   assign rsp_upper_half   = half_ff;

   // An accepted item keeps the block busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken but block not busy next cycle");

   // Never overwrite a result still waiting to be taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result loaded over a stalled result");

   // The narrow views agree with one another
   a_views_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fraction_q8 == rsp_fraction_q16[Q16_W-1 -: Q8_W]) &&
                    (rsp_upper_half == rsp_fraction_q8[Q8_W-1]))
      else $error("result views disagree");

endmodule

FILE: src/hri_datapath.sv
module hri_datapath
   import hri_pkg::*;
#(
   parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                     clock,
   input  hri_cmd_type              cmd,
   input  logic [INDEX_WIDTH-1:0]   sample_index,
   input  logic [BASE_W-1:0]        base,
   output hri_status_type           status,
   output logic [((FRACTION_BITS > Q16_W) ? FRACTION_BITS : Q16_W)-1:0] quotient
);

   localparam int QBITS   = (FRACTION_BITS > Q16_W) ? FRACTION_BITS : Q16_W;
   localparam int DIV_CYC = (INDEX_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_W   = DIV_CYC * DIV_STEPS;
   localparam int NUM_W   = INDEX_WIDTH + BASE_W;

   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [BASE_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  den_ff, den_in;
   logic [QBITS-1:0]  q_ff, q_in;

   logic [DIV_W-1:0]        div_quot;
   logic [BASE_W-1:0]       div_rem;
   logic [NUM_W+BASE_W-1:0] num_prod;
   logic [NUM_W+BASE_W-1:0] den_prod;
   logic [NUM_W:0]          num_dbl;

   // Digit divider: DIV_STEPS restoring steps on the running index
   always_comb begin
      logic [BASE_W:0] trial;
      div_quot = quot_ff;
      div_rem  = rem_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial    = {div_rem, div_quot[DIV_W-1]};
         div_quot = {div_quot[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, base}) begin
            div_rem     = BASE_W'(trial - {1'b0, base});
            div_quot[0] = 1'b1;
         end else begin
            div_rem = trial[BASE_W-1:0];
         end
      end
   end

   assign num_prod = num_ff * base;
   assign den_prod = den_ff * base;
   assign num_dbl  = {num_ff, 1'b0};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (cmd.load) begin
         quot_in = DIV_W'(sample_index);
         rem_in  = '0;
         num_in  = '0;
         den_in  = NUM_W'(1);
         q_in    = '0;
      end else if (cmd.div_step) begin
         quot_in = div_quot;
         rem_in  = div_rem;
      end else if (cmd.accum) begin
         // Append the digit to the mirrored numerator, grow the denominator
         num_in = num_prod[NUM_W-1:0] + NUM_W'(rem_ff);
         den_in = den_prod[NUM_W-1:0];
         rem_in = '0;
      end else if (cmd.frac_step) begin
         if (num_dbl >= {1'b0, den_ff}) begin
            num_in = NUM_W'(num_dbl - {1'b0, den_ff});
            q_in   = {q_ff[QBITS-2:0], 1'b1};
         end else begin
            num_in = num_dbl[NUM_W-1:0];
            q_in   = {q_ff[QBITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
   end

   assign status.quot_zero = (quot_ff == '0);
   assign quotient         = q_ff;

endmodule

FILE: src/hri_ctrl.sv
module hri_ctrl
   import hri_pkg::*;
#(
   parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           out_free,
   input  hri_status_type status,
   output hri_cmd_type    cmd,
   output logic           busy,
   output logic           out_load
);

   localparam int QBITS   = (FRACTION_BITS > Q16_W) ? FRACTION_BITS : Q16_W;
   localparam int DIV_CYC = (INDEX_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
   localparam int CNT_MAX = (DIV_CYC > QBITS) ? DIV_CYC : QBITS;
   localparam int CNT_W   = $clog2(CNT_MAX);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIVIDE;
               cnt_in   = CNT_W'(DIV_CYC - 1);
            end
         end
         ST_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = ST_ACCUM;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_ACCUM: begin
            if (status.quot_zero) begin
               state_in = ST_FRACT;
               cnt_in   = CNT_W'(QBITS - 1);
            end else begin
               state_in = ST_DIVIDE;
               cnt_in   = CNT_W'(DIV_CYC - 1);
            end
         end
         ST_FRACT: begin
            if (cnt_ff == '0) begin
               state_in = ST_OUTPUT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd      = '0;
      busy     = 1'b1;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         ST_FRACT: begin
            cmd.frac_step = 1'b1;
         end
         ST_OUTPUT: begin
            out_load = out_free;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
